@@ hdl/dls_pkg.sv @@
// shared types and constants for the decimal line sorter
// no dependencies; imported by every module of the block except dls_ram
package dls_pkg;

  // default queue depths
  localparam int unsigned LOW_DEPTH_DEF  = 16;
  localparam int unsigned HIGH_DEPTH_DEF = 16;

  // stored entry: {seq, part}
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned PART_W  = 16;
  localparam int unsigned ENTRY_W = SEQ_W + PART_W;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [0:0]  REG_SPLIT_THRESHOLD = 1'b0;
  localparam logic [PART_W-1:0] THRESHOLD_RESET = 16'd12;

  // characters
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // request codes
  localparam logic [1:0] REQ_BYTE     = 2'd0;
  localparam logic [1:0] REQ_POP_LOW  = 2'd1;
  localparam logic [1:0] REQ_POP_HIGH = 2'd2;
  localparam logic [1:0] REQ_EOS      = 2'd3;

  // status codes
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_ENQ   = 3'd1;
  localparam logic [2:0] ST_DEQ   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  // queue select
  localparam logic SEL_LOW  = 1'b0;
  localparam logic SEL_HIGH = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              queue_sel;
    logic [SEQ_W-1:0]  seq_num;
    logic [PART_W-1:0] part_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // item accepted this cycle
    logic capture;     // load popped entry from the queue ram
  } dls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;     // current item pops a non-empty queue
  } dls_sts_t;

endpackage

@@ hdl/dls_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
module dls_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/dls_ctrl.sv @@
// controller state machine: accept, ram read wait, result hold
// depends on dls_pkg
module dls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dls_pkg::dls_sts_t sts,
  output dls_pkg::dls_cmd_t cmd
);
  import dls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.take    = 1'b0;
    cmd.capture = 1'b0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.pop_hit ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/dls_dpath.sv @@
// datapath: digit accumulator, sequence counter, queue pointers, threshold register and result register
// depends on dls_pkg and dls_ram
module dls_dpath #(
  parameter int unsigned LOW_DEPTH  = dls_pkg::LOW_DEPTH_DEF,
  parameter int unsigned HIGH_DEPTH = dls_pkg::HIGH_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dls_pkg::in_item_t               in_data,
  input  dls_pkg::dls_cmd_t               cmd,
  output dls_pkg::dls_sts_t               sts,
  input  logic                            thr_we,
  input  logic [dls_pkg::PART_W-1:0]      thr_wdata,
  output logic [dls_pkg::PART_W-1:0]      thr,
  output dls_pkg::out_item_t              out_data
);
  import dls_pkg::*;

  localparam int unsigned LPW = $clog2(LOW_DEPTH);
  localparam int unsigned HPW = $clog2(HIGH_DEPTH);
  localparam int unsigned LCW = $clog2(LOW_DEPTH + 1);
  localparam int unsigned HCW = $clog2(HIGH_DEPTH + 1);
  localparam int unsigned PW  = PART_W + 4;

  logic [PART_W-1:0] thr_r;
  logic [PART_W-1:0] accum_r, accum_nxt;
  logic              stopped_r, stopped_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [LPW-1:0]    low_wp_r, low_rp_r;
  logic [HPW-1:0]    high_wp_r, high_rp_r;
  logic [LCW-1:0]    low_cnt_r;
  logic [HCW-1:0]    high_cnt_r;
  logic              pop_sel_r;
  out_item_t         out_r, out_nxt;

  logic low_full, high_full, low_empty, high_empty;
  logic low_we, high_we, low_re, high_re;
  logic [ENTRY_W-1:0] wentry;
  logic [ENTRY_W-1:0] low_rdata, high_rdata, pop_entry;
  logic is_nl, is_digit, go_low;
  logic [3:0]    digit;
  logic [PW-1:0] prod;

  assign low_full   = (low_cnt_r == LCW'(LOW_DEPTH));
  assign high_full  = (high_cnt_r == HCW'(HIGH_DEPTH));
  assign low_empty  = (low_cnt_r == '0);
  assign high_empty = (high_cnt_r == '0);

  assign sts.pop_hit = ((in_data.req_type == REQ_POP_LOW) && !low_empty) ||
                       ((in_data.req_type == REQ_POP_HIGH) && !high_empty);

  // digit accumulate with saturation
  assign is_nl    = (in_data.data_byte == CH_NEWLINE);
  assign is_digit = (in_data.data_byte >= CH_ZERO) && (in_data.data_byte <= CH_NINE);
  assign digit    = 4'(in_data.data_byte - CH_ZERO);
  assign prod     = PW'(accum_r) * PW'(10) + PW'(digit);
  assign go_low   = (accum_r <= thr_r);

  // per-item decode
  always_comb begin
    accum_nxt   = accum_r;
    stopped_nxt = stopped_r;
    seq_nxt     = seq_r;
    out_nxt     = '0;
    low_we      = 1'b0;
    high_we     = 1'b0;
    low_re      = 1'b0;
    high_re     = 1'b0;
    wentry      = {seq_r, accum_r};
    case (in_data.req_type)
      REQ_BYTE: begin
        if (is_nl) begin
          out_nxt.queue_sel  = go_low ? SEL_LOW : SEL_HIGH;
          out_nxt.seq_num    = seq_r;
          out_nxt.part_value = accum_r;
          if (go_low ? low_full : high_full) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status = ST_ENQ;
            low_we         = go_low;
            high_we        = !go_low;
            seq_nxt        = seq_r + SEQ_W'(1);
            accum_nxt      = '0;
            stopped_nxt    = 1'b0;
          end
        end else if (is_digit) begin
          if (!stopped_r) begin
            accum_nxt = (prod > PW'({PART_W{1'b1}})) ? {PART_W{1'b1}} : prod[PART_W-1:0];
          end
        end else begin
          stopped_nxt = 1'b1;
        end
      end
      REQ_POP_LOW: begin
        out_nxt.queue_sel = SEL_LOW;
        out_nxt.status    = low_empty ? ST_EMPTY : ST_DEQ;
        low_re            = !low_empty;
      end
      REQ_POP_HIGH: begin
        out_nxt.queue_sel = SEL_HIGH;
        out_nxt.status    = high_empty ? ST_EMPTY : ST_DEQ;
        high_re           = !high_empty;
      end
      default: begin
        wentry = '0;
        if (low_full || high_full) begin
          out_nxt.status    = ST_FULL;
          out_nxt.queue_sel = low_full ? SEL_LOW : SEL_HIGH;
        end else begin
          out_nxt.status = ST_ENQ;
          low_we         = 1'b1;
          high_we        = 1'b1;
          accum_nxt      = '0;
          stopped_nxt    = 1'b0;
        end
      end
    endcase
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (thr_we) begin
      thr_r <= thr_wdata;
    end
  end

  // line and queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r    <= '0;
      stopped_r  <= 1'b0;
      seq_r      <= '0;
      low_wp_r   <= '0;
      low_rp_r   <= '0;
      low_cnt_r  <= '0;
      high_wp_r  <= '0;
      high_rp_r  <= '0;
      high_cnt_r <= '0;
    end else if (cmd.take) begin
      accum_r   <= accum_nxt;
      stopped_r <= stopped_nxt;
      seq_r     <= seq_nxt;
      if (low_we) begin
        low_wp_r  <= (low_wp_r == LPW'(LOW_DEPTH - 1)) ? '0 : low_wp_r + LPW'(1);
        low_cnt_r <= low_cnt_r + LCW'(1);
      end
      if (low_re) begin
        low_rp_r  <= (low_rp_r == LPW'(LOW_DEPTH - 1)) ? '0 : low_rp_r + LPW'(1);
        low_cnt_r <= low_cnt_r - LCW'(1);
      end
      if (high_we) begin
        high_wp_r  <= (high_wp_r == HPW'(HIGH_DEPTH - 1)) ? '0 : high_wp_r + HPW'(1);
        high_cnt_r <= high_cnt_r + HCW'(1);
      end
      if (high_re) begin
        high_rp_r  <= (high_rp_r == HPW'(HIGH_DEPTH - 1)) ? '0 : high_rp_r + HPW'(1);
        high_cnt_r <= high_cnt_r - HCW'(1);
      end
    end
  end

  // result register; a pop fills seq and part in the following cycle, from the registered ram read
  assign pop_entry = pop_sel_r ? high_rdata : low_rdata;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      out_r     <= out_nxt;
      pop_sel_r <= out_nxt.queue_sel;
    end else if (cmd.capture) begin
      out_r.seq_num    <= pop_entry[ENTRY_W-1:PART_W];
      out_r.part_value <= pop_entry[PART_W-1:0];
    end
  end

  // queue storage
  dls_ram #(.WIDTH(ENTRY_W), .DEPTH(LOW_DEPTH)) u_low_ram (
    .clk   (clk),
    .we    (cmd.take && low_we),
    .waddr (low_wp_r),
    .wdata (wentry),
    .re    (cmd.take && low_re),
    .raddr (low_rp_r),
    .rdata (low_rdata)
  );

  dls_ram #(.WIDTH(ENTRY_W), .DEPTH(HIGH_DEPTH)) u_high_ram (
    .clk   (clk),
    .we    (cmd.take && high_we),
    .waddr (high_wp_r),
    .wdata (wentry),
    .re    (cmd.take && high_re),
    .raddr (high_rp_r),
    .rdata (high_rdata)
  );

  assign thr      = thr_r;
  assign out_data = out_r;

endmodule

@@ hdl/decimal_line_sorter_two_fifos.sv @@
// top level of the decimal line sorter with two ring queues
// depends on dls_pkg, dls_ctrl, dls_dpath (and dls_ram below it)
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  in_data (req_type, data_byte)
// out_      output     out_valid/out_stall  out_data (status, queue_sel, seq_num, part_value)
// cfg       input      psel/penable/pready  paddr, pwdata, prdata (split_threshold at 0)
//
// one item at a time: a byte, end of stream or pop of an empty queue goes
// through accept and then result; a pop of a non-empty queue adds a read state
// between them for the registered read of the queue ram.
// the result stays on out_data until out_stall is low; in_stall is high meanwhile.
// reset is synchronous on rst_n; queue contents are not cleared, no clearing pass.
module decimal_line_sorter_two_fifos #(
  parameter int unsigned LOW_DEPTH  = dls_pkg::LOW_DEPTH_DEF,
  parameter int unsigned HIGH_DEPTH = dls_pkg::HIGH_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dls_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dls_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dls_pkg::CFG_AW-1:0]  paddr,
  input  logic [dls_pkg::CFG_DW-1:0]  pwdata,
  output logic [dls_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import dls_pkg::*;

  dls_cmd_t          cmd;
  dls_sts_t          sts;
  logic              thr_we;
  logic              thr_sel;
  logic [PART_W-1:0] thr;

  // register decode
  assign pready  = 1'b1;
  assign thr_sel = (paddr[CFG_AW-1:2] == REG_SPLIT_THRESHOLD);
  assign thr_we  = psel && penable && pwrite && pready && thr_sel;
  assign prdata  = thr_sel ? CFG_DW'(thr) : '0;

  dls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dls_dpath #(.LOW_DEPTH(LOW_DEPTH), .HIGH_DEPTH(HIGH_DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .thr_we    (thr_we),
    .thr_wdata (pwdata[PART_W-1:0]),
    .thr       (thr),
    .out_data  (out_data)
  );

endmodule

@@ tb/decimal_line_sorter_two_fifos_test.sv @@
// testbench for decimal_line_sorter_two_fifos: random and directed byte/pop/eos items,
// results checked field by field against a predictor held in a small scoreboard class
// depends on dls_pkg and the decimal_line_sorter_two_fifos rtl
`timescale 1ns / 100ps

module decimal_line_sorter_two_fifos_test;
  import dls_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 250;

  // predictor of the sorter plus the store of expected results
  class part_queue_board;
    logic [PART_W-1:0]  threshold;
    logic [PART_W-1:0]  accum;
    bit                 stopped;
    logic [SEQ_W-1:0]   seq_ctr;
    logic [ENTRY_W-1:0] low_q[$];
    logic [ENTRY_W-1:0] high_q[$];
    out_item_t          expected_results[$];
    int                 errors;

    function new();
      threshold = THRESHOLD_RESET;
      accum     = '0;
      stopped   = 0;
      seq_ctr   = '0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // work out the result of one accepted item and update the predicted state
    function void accept_request(in_item_t it);
      out_item_t        r;
      logic [PART_W-1:0] part;
      int               v;
      bit               low_full;
      bit               high_full;
      r         = '0;
      low_full  = low_q.size() >= LOW_DEPTH_DEF;
      high_full = high_q.size() >= HIGH_DEPTH_DEF;
      case (it.req_type)
        REQ_BYTE: begin
          if (it.data_byte == CH_NEWLINE) begin
            part         = accum;
            r.queue_sel  = (part > threshold) ? SEL_HIGH : SEL_LOW;
            r.seq_num    = seq_ctr;
            r.part_value = part;
            if ((r.queue_sel == SEL_LOW) ? low_full : high_full) begin
              r.status = ST_FULL;
            end else begin
              r.status = ST_ENQ;
              if (r.queue_sel == SEL_LOW) low_q.push_back({seq_ctr, part});
              else high_q.push_back({seq_ctr, part});
              seq_ctr = seq_ctr + 1;
              accum   = '0;
              stopped = 0;
            end
          end else if (it.data_byte >= CH_ZERO && it.data_byte <= CH_NINE) begin
            if (!stopped) begin
              v     = int'(accum) * 10 + (int'(it.data_byte) - int'(CH_ZERO));
              accum = (v > 65535) ? 16'hffff : v[PART_W-1:0];
            end
            r.status = ST_NONE;
          end else begin
            stopped  = 1;
            r.status = ST_NONE;
          end
        end
        REQ_POP_LOW: begin
          r.queue_sel = SEL_LOW;
          if (low_q.size() == 0) r.status = ST_EMPTY;
          else begin
            r.status = ST_DEQ;
            {r.seq_num, r.part_value} = low_q.pop_front();
          end
        end
        REQ_POP_HIGH: begin
          r.queue_sel = SEL_HIGH;
          if (high_q.size() == 0) r.status = ST_EMPTY;
          else begin
            r.status = ST_DEQ;
            {r.seq_num, r.part_value} = high_q.pop_front();
          end
        end
        default: begin
          // end of stream: marker into both queues, partial line dropped
          if (low_full || high_full) begin
            r.status    = ST_FULL;
            r.queue_sel = low_full ? SEL_LOW : SEL_HIGH;
          end else begin
            r.status = ST_ENQ;
            low_q.push_back('0);
            high_q.push_back('0);
            accum   = '0;
            stopped = 0;
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("status", 32'(exp_r.status), 32'(got.status));
      compare_field("queue_sel", 32'(exp_r.queue_sel), 32'(got.queue_sel));
      compare_field("seq_num", exp_r.seq_num, got.seq_num);
      compare_field("part_value", 32'(exp_r.part_value), 32'(got.part_value));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  part_queue_board sorter = new();
  int n_sent       = 0;
  int gap_pct      = 0;
  int stall_pct    = 0;
  bit hold_request = 0;

  decimal_line_sorter_two_fifos i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result side: random stall bursts, one long hold on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_request) begin
        hold_request = 0;
        stall_left   = LONG_HOLD - 1;
        out_stall    <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 10);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // accepted results go to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sorter.check_result(out_data);
  end

  // watchdog on cycles with no item moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item and hold it until accepted, then maybe leave a gap
  task automatic offer_item(input in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sorter.accept_request(it);
    n_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic offer_byte(input logic [7:0] b);
    in_item_t it;
    it.req_type  = REQ_BYTE;
    it.data_byte = b;
    offer_item(it);
  endtask

  // non-byte request; the byte field carries junk
  task automatic offer_req(input logic [1:0] req);
    in_item_t it;
    it.req_type  = req;
    it.data_byte = 8'($urandom_range(0, 255));
    offer_item(it);
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i]);
  endtask

  // one line: digits (often near the threshold), maybe junk, then newline
  task automatic offer_line();
    int          v;
    int          ndig;
    logic [7:0]  junk;
    if ($urandom_range(0, 3) == 0) begin
      v = int'(sorter.threshold) + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      offer_text($sformatf("%0d", v));
    end else begin
      ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
      repeat (ndig) offer_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0) begin
      junk = 8'($urandom_range(0, 255));
      if (junk == CH_NEWLINE) junk = 8'h23;
      offer_byte(junk);
      repeat ($urandom_range(0, 2)) offer_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    offer_byte(CH_NEWLINE);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (sorter.pending() != 0) @(posedge clk);
  endtask

  // random mix of lines, pops, end of stream and noise
  task automatic run_phase(input int n, input int pop_pct);
    int stop_at;
    int pick;
    in_item_t it;
    stop_at = n_sent + n;
    while (n_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < pop_pct) begin
        offer_req($urandom_range(0, 1) ? REQ_POP_HIGH : REQ_POP_LOW);
      end else if (pick < pop_pct + 3) begin
        offer_req(REQ_EOS);
      end else if (pick < pop_pct + 10) begin
        it = in_item_t'($urandom_range(0, 1023));
        offer_item(it);
      end else begin
        offer_line();
      end
    end
  endtask

  // apb write of the threshold with read back, only while the block is idle
  task automatic set_threshold(input logic [PART_W-1:0] val);
    logic [CFG_AW-1:0] addr;
    addr = {REG_SPLIT_THRESHOLD, 2'b00};
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= CFG_DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sorter.threshold = val;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(val)) begin
      $error("split_threshold read back: expected %0h, got %0h", val, prdata);
      sorter.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pops, zero part, saturation, threshold boundary,
    // digits after a non-digit, lines with no leading digit, end of stream
    gap_pct   = 20;
    stall_pct = 20;
    offer_req(REQ_POP_LOW);
    offer_req(REQ_POP_HIGH);
    offer_text("0\n");
    offer_text("99999\n");
    offer_text("12:3\n");
    offer_text("13\n");
    offer_byte(8'h00);
    offer_byte(8'hff);
    offer_byte(8'h2f);
    offer_byte(CH_NEWLINE);
    offer_req(REQ_EOS);
    offer_req(REQ_POP_LOW);
    offer_req(REQ_POP_HIGH);

    // reset threshold, with one pause until every result is back
    run_phase(150, 40);
    wait_drained();
    run_phase(150, 40);

    // everything nonzero goes high; long receiver hold while the sender pushes
    set_threshold(16'd0);
    hold_request = 1;
    run_phase(300, 15);

    // everything goes low; fill, then drain
    set_threshold(16'hffff);
    run_phase(300, 15);
    run_phase(150, 75);

    // random threshold, first without idling then with heavy idling
    set_threshold(16'($urandom_range(0, 65535)));
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(150, 40);
    gap_pct   = 30;
    stall_pct = 30;
    run_phase(200, 40);

    // closing stretch with no idling on either side
    set_threshold(16'd1000);
    gap_pct   = 0;
    stall_pct = 0;
    run_phase(300, 40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sorter.pending() != 0) begin
      $error("%0d expected results never arrived", sorter.pending());
      sorter.errors++;
    end
    if (sorter.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
